// ===== rtl/core/ssprc_pkg.sv =====
// Package for the servo status packet receiver: codes, register map and result type.
`timescale 1ns / 1ps

package ssprc_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'hFF;
  localparam logic [1:0] HEADER_LAST  = 2'd2;   // index of the error byte in the header
  localparam logic [7:0] MIN_LENGTH   = 8'd2;

  localparam logic       OP_BYTE      = 1'b0;
  localparam logic       OP_TICK      = 1'b1;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_END     = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_NORESP    = 2'd2;
  localparam logic [1:0] ST_CORRUPT   = 2'd3;

  // Register select is paddr[2].
  localparam logic       REG_PACKET_WAIT = 1'b0;
  localparam logic       REG_BYTE_WAIT   = 1'b1;

  localparam logic [15:0] PACKET_WAIT_RESET = 16'd100;
  localparam logic [7:0]  BYTE_WAIT_RESET   = 8'd12;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [7:0] payload_length;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

// ===== rtl/core/servo_status_packet_receiver_core.sv =====
// Top level of the servo status packet receiver.
`timescale 1ns / 1ps

// Servo status packet receiver.
// Input stream (s_*): one transaction is either a received serial byte
// (s_tuser = 0, byte in s_tdata) or one time tick (s_tuser = 1).
// The parser hunts for two 0xFF sync bytes, takes id, length and error,
// forwards length-2 payload bytes and checks the inverted 8-bit sum.
// Output stream (m_*): a payload byte (m_tuser = 0) or an end report
// (m_tuser = 1, m_tlast = 1) carrying id, error, payload length, status
// (ok, timeout, no response, corrupt). At most one output per input.
// Results are registered on m_* or in the skid entry. Throughput: one
// input per cycle while s_tready is high, set by the single register
// stage around the parser state update (one 8x8 budget multiply + compare).
// Stall: an output register plus one skid entry sit on the master side;
// s_tready drops only when both hold results that m_tready has not taken.
// Inputs that give no result still need a free skid to be accepted.
// Reset (rst, synchronous): parser back to sync hunting, budgets back to
// 100 ticks (hunt) and 12 ticks per byte; no reset pass is needed.
// APB: register 0 at 0x0 packet_wait_ticks, register 1 at 0x4 byte_wait_ticks.
module servo_status_packet_receiver_core (
  input  logic        clk,
  input  logic        rst,
  // stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] operation
  // stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] servo_id, [23:16] servo_error,
                                 // [31:24] payload_length, [33:32] status, [39:34] zero
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  // config registers
  logic [15:0] packet_wait_ticks;
  logic [7:0]  byte_wait_ticks;

  // parser state
  phase_t      phase, phase_next;
  logic [1:0]  sync_seen, sync_seen_next;
  logic [1:0]  header_index, header_index_next;
  logic [7:0]  held_id, held_id_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  held_error, held_error_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] phase_ticks, phase_ticks_next;

  // output register and skid entry
  ssprc_pkg::result_t out_q, skid_q, res;
  logic        skid_valid;
  logic        has_res;

  logic        accept;
  logic        out_free;
  logic [7:0]  pay_len;
  logic [7:0]  new_len;
  logic [1:0]  sync_cnt;
  logic [15:0] budget;
  logic [15:0] payload_budget;
  logic [7:0]  sum_add;

  assign pready   = 1'b1;
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign m_tuser = out_q.kind;
  assign m_tlast = out_q.last;
  assign m_tdata = {6'd0, out_q.status, out_q.payload_length, out_q.servo_error,
                    out_q.servo_id, out_q.payload_byte};

  // APB
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_wait_ticks <= ssprc_pkg::PACKET_WAIT_RESET;
      byte_wait_ticks   <= ssprc_pkg::BYTE_WAIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == ssprc_pkg::REG_PACKET_WAIT) begin
        packet_wait_ticks <= pwdata[15:0];
      end else begin
        byte_wait_ticks <= pwdata[7:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == ssprc_pkg::REG_PACKET_WAIT) begin
      prdata = {16'd0, packet_wait_ticks};
    end else begin
      prdata = {24'd0, byte_wait_ticks};
    end
  end

  // held_length is always >= 2 in payload and checksum phases
  assign pay_len = (held_length >= ssprc_pkg::MIN_LENGTH) ?
                   8'(held_length - ssprc_pkg::MIN_LENGTH) : 8'd0;
  assign payload_budget = 16'(byte_wait_ticks) * 16'(pay_len);
  assign sum_add  = 8'(running_sum + s_tdata);
  assign sync_cnt = (s_tdata == ssprc_pkg::SYNC_BYTE) ? 2'(sync_seen + 2'd1) : 2'd0;

  always_comb begin
    unique case (phase)
      PH_HUNT:    budget = packet_wait_ticks;
      PH_HEADER:  budget = 16'({byte_wait_ticks, 1'b0}) + 16'(byte_wait_ticks);
      PH_PAYLOAD: budget = payload_budget;
      PH_CHECK:   budget = 16'(byte_wait_ticks);
      default:    budget = 16'(byte_wait_ticks);
    endcase
  end

  // parser next state and result
  always_comb begin
    phase_next        = phase;
    sync_seen_next    = sync_seen;
    header_index_next = header_index;
    held_id_next      = held_id;
    held_length_next  = held_length;
    held_error_next   = held_error;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    phase_ticks_next  = phase_ticks;
    new_len           = 8'd0;
    res               = '0;
    has_res           = 1'b0;

    if (s_tuser == ssprc_pkg::OP_TICK) begin
      if (phase_ticks >= budget) begin
        has_res  = 1'b1;
        res.kind = ssprc_pkg::KIND_END;
        res.last = 1'b1;
        unique case (phase)
          PH_PAYLOAD: begin
            res.status         = ssprc_pkg::ST_NORESP;
            res.servo_id       = held_id;
            res.servo_error    = held_error;
            res.payload_length = pay_len;
          end
          PH_CHECK: begin
            res.status         = ssprc_pkg::ST_CORRUPT;
            res.servo_id       = held_id;
            res.servo_error    = held_error;
            res.payload_length = pay_len;
          end
          default: begin
            res.status = ssprc_pkg::ST_TIMEOUT;
          end
        endcase
        phase_next        = PH_HUNT;
        phase_ticks_next  = 16'd0;
        sync_seen_next    = 2'd0;
        header_index_next = 2'd0;
      end else begin
        phase_ticks_next = 16'(phase_ticks + 16'd1);
      end
    end else begin
      unique case (phase)
        PH_HUNT: begin
          sync_seen_next = sync_cnt;
          if (sync_cnt >= 2'd2) begin
            held_id_next      = 8'd0;
            held_length_next  = 8'd0;
            held_error_next   = 8'd0;
            running_sum_next  = 8'd0;
            phase_next        = PH_HEADER;
            phase_ticks_next  = 16'd0;
            sync_seen_next    = 2'd0;
            header_index_next = 2'd0;
          end
        end
        PH_HEADER: begin
          running_sum_next = sum_add;
          if (header_index == 2'd0) begin
            held_id_next      = s_tdata;
            header_index_next = 2'd1;
          end else if (header_index == 2'd1) begin
            held_length_next  = s_tdata;
            header_index_next = ssprc_pkg::HEADER_LAST;
          end else begin
            held_error_next   = s_tdata;
            phase_ticks_next  = 16'd0;
            sync_seen_next    = 2'd0;
            header_index_next = 2'd0;
            if (held_length < ssprc_pkg::MIN_LENGTH) begin
              // length too short: report corrupt with the header kept
              has_res            = 1'b1;
              res.kind           = ssprc_pkg::KIND_END;
              res.last           = 1'b1;
              res.status         = ssprc_pkg::ST_CORRUPT;
              res.servo_id       = held_id;
              res.servo_error    = s_tdata;
              res.payload_length = 8'd0;
              phase_next         = PH_HUNT;
            end else begin
              new_len         = 8'(held_length - ssprc_pkg::MIN_LENGTH);
              bytes_left_next = new_len;
              phase_next      = (new_len != 8'd0) ? PH_PAYLOAD : PH_CHECK;
            end
          end
        end
        PH_PAYLOAD: begin
          running_sum_next = sum_add;
          has_res          = 1'b1;
          res.kind         = ssprc_pkg::KIND_PAYLOAD;
          res.payload_byte = s_tdata;
          bytes_left_next  = 8'(bytes_left - 8'd1);
          if (bytes_left == 8'd1) begin
            phase_next        = PH_CHECK;
            phase_ticks_next  = 16'd0;
            sync_seen_next    = 2'd0;
            header_index_next = 2'd0;
          end
        end
        PH_CHECK: begin
          has_res  = 1'b1;
          res.kind = ssprc_pkg::KIND_END;
          res.last = 1'b1;
          if (~running_sum == s_tdata) begin
            res.status         = ssprc_pkg::ST_OK;
            res.servo_id       = held_id;
            res.servo_error    = held_error;
            res.payload_length = pay_len;
          end else begin
            res.status = ssprc_pkg::ST_CORRUPT;
          end
          phase_next        = PH_HUNT;
          phase_ticks_next  = 16'd0;
          sync_seen_next    = 2'd0;
          header_index_next = 2'd0;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      sync_seen    <= 2'd0;
      header_index <= 2'd0;
      held_id      <= 8'd0;
      held_length  <= 8'd0;
      held_error   <= 8'd0;
      bytes_left   <= 8'd0;
      running_sum  <= 8'd0;
      phase_ticks  <= 16'd0;
    end else if (accept) begin
      phase        <= phase_next;
      sync_seen    <= sync_seen_next;
      header_index <= header_index_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      held_error   <= held_error_next;
      bytes_left   <= bytes_left_next;
      running_sum  <= running_sum_next;
      phase_ticks  <= phase_ticks_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept && has_res;
      end
    end else if (accept && has_res) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_q <= skid_q;
      end else begin
        out_q <= res;
      end
    end else if (accept && has_res) begin
      skid_q <= res;
    end
  end

endmodule

// ===== tb/servo_status_packet_receiver_core_test.sv =====
// Self-checking stream testbench for the servo status packet receiver core.
`timescale 1ns / 1ps

module servo_status_packet_receiver_core_test;

  // Parser phases of the local predictor.
  typedef enum logic [1:0] {P_HUNT, P_HEADER, P_PAYLOAD, P_CHECKSUM} parse_phase_t;

  // One input transaction: a received byte or a time tick.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } rx_item_t;

  // Directed table row: either a register write or one input transaction,
  // optionally with the end report typed in by hand.
  typedef struct packed {
    logic                is_cfg;
    logic                reg_sel;
    logic [31:0]         value;
    logic                has_want;
    rx_item_t            item;
    ssprc_pkg::result_t  want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] rx_byte
  logic        s_tuser = 1'b0;   // [0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;          // [7:0] payload_byte, [15:8] servo_id, [23:16] servo_error,
                                 // [31:24] payload_length, [33:32] status, [39:34] zero
  logic        m_tuser;          // [0] kind
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  servo_status_packet_receiver_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor state: its own copy of the budgets and the parser.
  // ---------------------------------------------------------------------
  logic [15:0]  hunt_limit;
  logic [7:0]   per_byte_limit;
  parse_phase_t phase;
  logic [1:0]   sync_count;
  logic [1:0]   header_pos;
  logic [7:0]   hold_id;
  logic [7:0]   hold_len;
  logic [7:0]   hold_err;
  logic [7:0]   bytes_due;
  logic [7:0]   check_sum;
  logic [15:0]  phase_ticks;

  ssprc_pkg::result_t expected_q[$];   // results still owed by the block, oldest first
  rx_item_t           traffic_q[$];    // random transactions waiting to be sent
  plan_row_t          plan_q[$];       // directed table

  int errors = 0;
  int burst_left = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int stall_cycle = 0;

  function automatic logic [7:0] payload_count();
    return (hold_len >= ssprc_pkg::MIN_LENGTH) ? hold_len - ssprc_pkg::MIN_LENGTH : 8'd0;
  endfunction

  // Ticks the current phase may absorb before the next one ends the packet.
  function automatic int tick_budget();
    unique case (phase)
      P_HUNT:    return int'(hunt_limit);
      P_HEADER:  return 3 * int'(per_byte_limit);
      P_PAYLOAD: return int'(per_byte_limit) * int'(payload_count());
      default:   return int'(per_byte_limit);
    endcase
  endfunction

  function automatic ssprc_pkg::result_t make_report(input logic [1:0] st,
                                                     input logic [7:0] id,
                                                     input logic [7:0] err,
                                                     input logic [7:0] len);
    ssprc_pkg::result_t r;
    r                = '0;
    r.kind           = ssprc_pkg::KIND_END;
    r.servo_id       = id;
    r.servo_error    = err;
    r.payload_length = len;
    r.status         = st;
    r.last           = 1'b1;
    return r;
  endfunction

  task automatic enter_phase(input parse_phase_t p);
    phase       = p;
    phase_ticks = '0;
    sync_count  = '0;
    header_pos  = '0;
  endtask

  // Advance the parser by one accepted transaction; emits tells whether a
  // result is owed for it.
  task automatic parse_input(input rx_item_t it, output bit emits,
                             output ssprc_pkg::result_t r);
    emits = 1'b0;
    r     = '0;
    if (it.op == ssprc_pkg::OP_TICK) begin
      if (int'(phase_ticks) >= tick_budget()) begin
        emits = 1'b1;
        unique case (phase)
          P_PAYLOAD:  r = make_report(ssprc_pkg::ST_NORESP, hold_id, hold_err,
                                      payload_count());
          P_CHECKSUM: r = make_report(ssprc_pkg::ST_CORRUPT, hold_id, hold_err,
                                      payload_count());
          default:    r = make_report(ssprc_pkg::ST_TIMEOUT, 8'd0, 8'd0, 8'd0);
        endcase
        enter_phase(P_HUNT);
      end else begin
        phase_ticks = phase_ticks + 16'd1;
      end
    end else begin
      unique case (phase)
        P_HUNT: begin
          sync_count = (it.data == ssprc_pkg::SYNC_BYTE) ? sync_count + 2'd1 : 2'd0;
          if (sync_count >= 2'd2) begin
            hold_id   = '0;
            hold_len  = '0;
            hold_err  = '0;
            check_sum = '0;
            enter_phase(P_HEADER);
          end
        end
        P_HEADER: begin
          unique case (header_pos)
            2'd0:    hold_id = it.data;
            2'd1:    hold_len = it.data;
            default: hold_err = it.data;
          endcase
          check_sum = check_sum + it.data;
          if (header_pos == ssprc_pkg::HEADER_LAST) begin
            if (hold_len < ssprc_pkg::MIN_LENGTH) begin
              // short length: packet dropped as corrupt right after the header
              emits = 1'b1;
              r     = make_report(ssprc_pkg::ST_CORRUPT, hold_id, hold_err, 8'd0);
              enter_phase(P_HUNT);
            end else begin
              bytes_due = payload_count();
              if (bytes_due != 8'd0) enter_phase(P_PAYLOAD);
              else enter_phase(P_CHECKSUM);
            end
          end else begin
            header_pos = header_pos + 2'd1;
          end
        end
        P_PAYLOAD: begin
          check_sum      = check_sum + it.data;
          emits          = 1'b1;
          r.kind         = ssprc_pkg::KIND_PAYLOAD;
          r.payload_byte = it.data;
          r.status       = ssprc_pkg::ST_OK;
          r.last         = 1'b0;
          bytes_due      = bytes_due - 8'd1;
          if (bytes_due == 8'd0) enter_phase(P_CHECKSUM);
        end
        default: begin
          emits = 1'b1;
          if (8'(~check_sum) == it.data)
            r = make_report(ssprc_pkg::ST_OK, hold_id, hold_err, payload_count());
          else
            r = make_report(ssprc_pkg::ST_CORRUPT, 8'd0, 8'd0, 8'd0);
          enter_phase(P_HUNT);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // Sender side. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------

  // Offer one transaction; bursts of random length, random gaps between
  // them, and now and then a pause until the block has drained.
  task automatic offer_item(input rx_item_t it, input bit has_want,
                            input ssprc_pkg::result_t want);
    bit                 emits;
    ssprc_pkg::result_t got;
    int                 gap;
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      if ($urandom_range(0, 24) == 0) begin
        @(negedge clk);
        while (expected_q.size() != 0) @(negedge clk);
      end else begin
        gap = $urandom_range(1, 8);
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tuser  = it.op;
    s_tdata  = it.data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_input(it, emits, got);
    if (has_want) expected_q.push_back(want);
    else if (emits) expected_q.push_back(got);
    @(negedge clk);
  endtask

  // Block idle: nothing owed, plus an extra wait for a transaction that
  // gave no result but may still sit in the pipeline.
  task automatic wait_idle();
    s_tvalid   = 1'b0;
    burst_left = 0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic sel, input logic [31:0] value);
    logic [31:0] field;
    field   = (sel == ssprc_pkg::REG_PACKET_WAIT) ? {16'd0, value[15:0]} :
                                                     {24'd0, value[7:0]};
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (sel == ssprc_pkg::REG_PACKET_WAIT) hunt_limit = value[15:0];
    else per_byte_limit = value[7:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== field) begin
      $display("%0t: register %0d read-back mismatch, expected %0h, actual %0h",
               $time, sel, field, prdata);
      errors++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Directed table builders.
  // ---------------------------------------------------------------------
  task automatic plan_item(input logic op, input logic [7:0] data);
    plan_row_t r;
    r           = '0;
    r.item.op   = op;
    r.item.data = data;
    plan_q.push_back(r);
  endtask

  task automatic plan_report(input logic op, input logic [7:0] data,
                             input ssprc_pkg::result_t want);
    plan_row_t r;
    r           = '0;
    r.item.op   = op;
    r.item.data = data;
    r.has_want  = 1'b1;
    r.want      = want;
    plan_q.push_back(r);
  endtask

  task automatic plan_write(input logic sel, input logic [31:0] value);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_sel = sel;
    r.value   = value;
    plan_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------
  // Random traffic: mostly well-formed packets with random content, some
  // noise, truncated packets followed by tick runs, stray tick runs.
  // ---------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [7:0] data);
    rx_item_t it;
    it.op   = op;
    it.data = data;
    traffic_q.push_back(it);
  endtask

  task automatic build_traffic(input int count);
    logic [7:0] pkt[$];
    logic [7:0] csum;
    logic [7:0] len;
    int         pick;
    int         n;
    int         cut;
    while (traffic_q.size() < count) begin
      pick = $urandom_range(0, 99);
      pkt  = {};
      if (pick < 8) begin
        n = $urandom_range(1, 4);
        repeat (n)
          pkt.push_back(($urandom_range(0, 2) == 0) ? ssprc_pkg::SYNC_BYTE : 8'($urandom));
      end else begin
        pkt.push_back(ssprc_pkg::SYNC_BYTE);
        pkt.push_back(ssprc_pkg::SYNC_BYTE);
        // id: now and then a third sync byte
        pkt.push_back(($urandom_range(0, 7) == 0) ? ssprc_pkg::SYNC_BYTE : 8'($urandom));
        n = $urandom_range(0, 99);
        if (n < 8) len = 8'($urandom_range(0, 1));
        else if (n < 12) len = 8'($urandom_range(2, 255));
        else len = 8'($urandom_range(2, 12));
        pkt.push_back(len);
        pkt.push_back(8'($urandom));
        if (len >= ssprc_pkg::MIN_LENGTH)
          repeat (len - ssprc_pkg::MIN_LENGTH) pkt.push_back(8'($urandom));
        csum = 8'd0;
        foreach (pkt[i]) if (i >= 2) csum = csum + pkt[i];
        pkt.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(~csum));
        if (pick < 25) begin
          cut = $urandom_range(2, pkt.size() - 1);
          while (pkt.size() > cut) void'(pkt.pop_back());
        end
      end
      foreach (pkt[i]) begin
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) queue_item(ssprc_pkg::OP_TICK, 8'($urandom));
        queue_item(ssprc_pkg::OP_BYTE, pkt[i]);
      end
      if (pick < 25 || $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 40)) queue_item(ssprc_pkg::OP_TICK, 8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: its own stall pattern, plus long hold-offs on request.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = 300;
      m_tready  = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      stall_cycle++;
      unique case (stall_mode)
        0:       m_tready = 1'b1;
        1:       m_tready = 1'($urandom_range(0, 1));
        2:       m_tready = (stall_cycle % 3 == 0);
        default: m_tready = ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Every output transaction is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    ssprc_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none owed, expected none, actual tdata %h user %b last %b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("kind", 8'(want.kind), 8'(m_tuser));
        check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
        check_field("servo_id", want.servo_id, m_tdata[15:8]);
        check_field("servo_error", want.servo_error, m_tdata[23:16]);
        check_field("payload_length", want.payload_length, m_tdata[31:24]);
        check_field("status", 8'(want.status), 8'(m_tdata[33:32]));
        check_field("last", 8'(want.last), 8'(m_tlast));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin : main_flow
    plan_row_t row;
    hunt_limit     = ssprc_pkg::PACKET_WAIT_RESET;
    per_byte_limit = ssprc_pkg::BYTE_WAIT_RESET;
    hold_id        = '0;
    hold_len       = '0;
    hold_err       = '0;
    bytes_due      = '0;
    check_sum      = '0;
    enter_phase(P_HUNT);

    // Reset budgets. Good packet with one payload byte.
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'h00);
    plan_item(ssprc_pkg::OP_BYTE, 8'h03);
    plan_item(ssprc_pkg::OP_BYTE, 8'h00);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_report(ssprc_pkg::OP_BYTE, 8'hFD,
                make_report(ssprc_pkg::ST_OK, 8'h00, 8'h00, 8'd1));
    // Third sync byte taken as id, then length below two.
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'h01);
    plan_report(ssprc_pkg::OP_BYTE, 8'hAB,
                make_report(ssprc_pkg::ST_CORRUPT, 8'hFF, 8'hAB, 8'd0));
    // Length two, no payload, checksum wrong.
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'h5A);
    plan_item(ssprc_pkg::OP_BYTE, 8'h02);
    plan_item(ssprc_pkg::OP_BYTE, 8'h80);
    plan_report(ssprc_pkg::OP_BYTE, 8'h00,
                make_report(ssprc_pkg::ST_CORRUPT, 8'h00, 8'h00, 8'h00));
    // Zero budgets: the first tick of any phase ends the packet.
    plan_write(ssprc_pkg::REG_PACKET_WAIT, 32'hABCD_0000);
    plan_write(ssprc_pkg::REG_BYTE_WAIT, 32'h1234_5600);
    plan_report(ssprc_pkg::OP_TICK, 8'h5C,
                make_report(ssprc_pkg::ST_TIMEOUT, 8'h00, 8'h00, 8'h00));
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_report(ssprc_pkg::OP_TICK, 8'hA3,
                make_report(ssprc_pkg::ST_TIMEOUT, 8'h00, 8'h00, 8'h00));
    // Checksum byte never arrives.
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'hFF);
    plan_item(ssprc_pkg::OP_BYTE, 8'h07);
    plan_item(ssprc_pkg::OP_BYTE, 8'h02);
    plan_item(ssprc_pkg::OP_BYTE, 8'h00);
    plan_report(ssprc_pkg::OP_TICK, 8'hFF,
                make_report(ssprc_pkg::ST_CORRUPT, 8'h07, 8'h00, 8'd0));

    repeat (6) @(negedge clk);
    rst = 1'b0;

    while (plan_q.size() != 0) begin
      row = plan_q.pop_front();
      if (row.is_cfg) begin
        wait_idle();
        write_reg(row.reg_sel, row.value);
      end else begin
        offer_item(row.item, row.has_want, row.want);
      end
    end

    // Random phases, each under its own budget setting.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      unique case (p)
        0: begin
          write_reg(ssprc_pkg::REG_PACKET_WAIT, {16'($urandom), 16'hFFFF});
          write_reg(ssprc_pkg::REG_BYTE_WAIT, {24'($urandom), 8'hFF});
        end
        1: begin
          write_reg(ssprc_pkg::REG_PACKET_WAIT, 32'(ssprc_pkg::PACKET_WAIT_RESET));
          write_reg(ssprc_pkg::REG_BYTE_WAIT, 32'(ssprc_pkg::BYTE_WAIT_RESET));
        end
        7: begin
          write_reg(ssprc_pkg::REG_PACKET_WAIT, $urandom);
          write_reg(ssprc_pkg::REG_BYTE_WAIT, $urandom);
        end
        default: begin
          // tight budgets so that timeouts of every phase are frequent
          write_reg(ssprc_pkg::REG_PACKET_WAIT, $urandom_range(0, 40));
          write_reg(ssprc_pkg::REG_BYTE_WAIT, $urandom_range(0, 5));
        end
      endcase
      build_traffic(250);
      // long receiver hold-off while the sender keeps offering
      if (p == 1) hold_requests++;
      while (traffic_q.size() != 0) offer_item(traffic_q.pop_front(), 1'b0, '0);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ssprc_pkg.sv
rtl/core/servo_status_packet_receiver_core.sv
tb/servo_status_packet_receiver_core_test.sv
